@@ rtl/cleb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types, codes and helpers for the cursor line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

    // default line store depth
    localparam int LINE_DEPTH_DEF = 64;

    // special keys
    localparam logic [7:0] KEY_LEFT  = 8'h3C; // '<'
    localparam logic [7:0] KEY_RIGHT = 8'h3E; // '>'
    localparam logic [7:0] KEY_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] KEY_MINUS = 8'h2D; // '-'

    // input op codes
    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_CHAR    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NOP         = 4'd0;
    localparam logic [3:0] CMD_INSERT      = 4'd1;
    localparam logic [3:0] CMD_LEFT        = 4'd2;
    localparam logic [3:0] CMD_RIGHT       = 4'd3;
    localparam logic [3:0] CMD_TOGGLE      = 4'd4;
    localparam logic [3:0] CMD_DELETE      = 4'd5;
    localparam logic [3:0] CMD_REPORT      = 4'd6;
    localparam logic [3:0] CMD_FLUSH_START = 4'd7;
    localparam logic [3:0] CMD_FLUSH_STEP  = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic len_zero;
        logic len_one;
        logic full;
        logic cur_zero;
        logic cur_at_end;
        logic out_free;
    } t_dp_stat;

    function automatic logic is_upper(input logic [7:0] k);
        return (k >= 8'h41) && (k <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] k);
        return (k >= 8'h61) && (k <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] k);
        return ((k >= 8'h30) && (k <= 8'h39)) || is_upper(k) || is_lower(k);
    endfunction

endpackage

@@ rtl/cleb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_ctrl
// Key decode and flush sequencing; issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module cleb_ctrl
    import cleb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_op,
    input  logic [7:0] i_key,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and command
    always_comb begin
        n_state      = r_state;
        o_cmd.op     = CMD_NOP;
        o_cmd.status = ST_CHAR;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_FINISH) begin
                        if (i_stat.len_zero) begin
                            o_cmd.op     = CMD_REPORT;
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = CMD_FLUSH_START;
                            n_state  = ST_FLUSH;
                        end
                    end else if (is_alnum(i_key)) begin
                        if (i_stat.full) begin
                            o_cmd.op     = CMD_REPORT;
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.op = CMD_INSERT;
                        end
                    end else begin
                        case (i_key)
                            KEY_LEFT:  o_cmd.op = i_stat.cur_zero   ? CMD_NOP : CMD_LEFT;
                            KEY_RIGHT: o_cmd.op = i_stat.cur_at_end ? CMD_NOP : CMD_RIGHT;
                            KEY_PLUS:  o_cmd.op = i_stat.cur_zero   ? CMD_NOP : CMD_TOGGLE;
                            KEY_MINUS: o_cmd.op = i_stat.cur_zero   ? CMD_NOP : CMD_DELETE;
                            default: begin
                                o_cmd.op     = CMD_REPORT;
                                o_cmd.status = ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH: begin
                // one character per free output slot
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_FLUSH_STEP;
                    if (i_stat.len_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/cleb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_dp
// Row of character cells with length and cursor, plus the result register.
// ----------------------------------------------------------------------------
module cleb_dp
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_key,
    input  t_dp_cmd    i_cmd,
    input  logic       i_out_ready,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_char_out,
    output logic       o_last,
    output logic [1:0] o_status
);

    localparam int LW = $clog2(LINE_DEPTH + 1);

    logic [7:0]    r_cells [LINE_DEPTH];
    logic [7:0]    n_cells [LINE_DEPTH];
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] n_cur;
    logic          r_out_valid;
    logic [7:0]    r_char;
    logic          r_last;
    logic [1:0]    r_status;
    logic          w_load;

    // status to controller
    assign o_stat.len_zero   = (r_len == '0);
    assign o_stat.len_one    = (r_len == LW'(1));
    assign o_stat.full       = (r_len == LW'(LINE_DEPTH));
    assign o_stat.cur_zero   = (r_cur == '0);
    assign o_stat.cur_at_end = (r_cur == r_len);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // per-cell next value, each cell looks only at its neighbors
    always_comb begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            case (i_cmd.op)
                CMD_INSERT: begin
                    if (LW'(i) == r_cur) begin
                        n_cells[i] = i_key;
                    end else if ((i > 0) && (LW'(i) > r_cur)) begin
                        n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                    end
                end
                CMD_DELETE: begin
                    if ((i < LINE_DEPTH - 1) && (LW'(i + 1) >= r_cur)) begin
                        n_cells[i] = r_cells[(i < LINE_DEPTH - 1) ? i + 1 : i];
                    end
                end
                CMD_TOGGLE: begin
                    // flip bit 5 on letters only
                    if ((LW'(i + 1) == r_cur)
                        && (is_upper(r_cells[i]) || is_lower(r_cells[i]))) begin
                        n_cells[i] = r_cells[i] ^ 8'h20;
                    end
                end
                CMD_FLUSH_STEP: begin
                    if (i < LINE_DEPTH - 1) begin
                        n_cells[i] = r_cells[(i < LINE_DEPTH - 1) ? i + 1 : i];
                    end
                end
                default: ;
            endcase
        end
    end

    // length and cursor
    always_comb begin
        n_len = r_len;
        n_cur = r_cur;
        case (i_cmd.op)
            CMD_INSERT: begin
                n_len = r_len + LW'(1);
                n_cur = r_cur + LW'(1);
            end
            CMD_LEFT:        n_cur = r_cur - LW'(1);
            CMD_RIGHT:       n_cur = r_cur + LW'(1);
            CMD_DELETE: begin
                n_len = r_len - LW'(1);
                n_cur = r_cur - LW'(1);
            end
            CMD_FLUSH_START: n_cur = '0;
            // length doubles as the flush countdown
            CMD_FLUSH_STEP:  n_len = r_len - LW'(1);
            default: ;
        endcase
    end

    assign w_load = (i_cmd.op == CMD_REPORT) || (i_cmd.op == CMD_FLUSH_STEP);

    // cell row, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            r_cells[i] <= n_cells[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            r_cur <= n_cur;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_FLUSH_STEP) begin
            r_char   <= r_cells[0];
            r_last   <= (r_len == LW'(1));
            r_status <= ST_CHAR;
        end else if (i_cmd.op == CMD_REPORT) begin
            r_char   <= (i_cmd.status == ST_EMPTY) ? 8'h00 : i_key;
            r_last   <= 1'b1;
            r_status <= i_cmd.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

@@ rtl/cursor_line_edit_buffer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_core
// Keystroke-driven line editor with a cursor and a flush of the line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per keystroke:
//   i_op = 0 edits with i_key, i_op = 1 finishes the line.
//   Output channel (o_out_valid / i_out_ready) carries result words:
//   o_char_out, o_last, o_status.
// Timing and throughput:
//   A result that an input word raises (invalid key, full line, empty line)
//   is shown in the next cycle from the output register.
//   A finish of a non-empty line starts the run, then sends one character
//   per cycle while the output is free, paced by the output register; no
//   input word is taken during that run.
//   Back to back edit keys are taken every cycle while the output is free.
// Stall:
//   While a result waits untaken, o_in_ready stays low and the result holds.
// Reset:
//   Synchronous, active low: line length and cursor go to zero, the output
//   register empties. Cell contents are not cleared.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_core
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_key,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic       o_last,
    output logic [1:0] o_status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cleb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_key      (i_key),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    cleb_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_key),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_char_out  (o_char_out),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule

@@ rtl/cleb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cleb_checker
// Port-level checks for the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module cleb_checker
    import cleb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_char_out,
    input logic       o_last,
    input logic [1:0] o_status
);

    // a waiting result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // no new input word while a result is stuck
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // single-word results always end the run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_CHAR) |-> o_last)
        else $error("non-character result without last");

    // empty line carries a zero character
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_char_out == 8'h00))
        else $error("empty line result with nonzero character");

endmodule

bind cursor_line_edit_buffer_core cleb_checker u_cleb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_char_out  (o_char_out),
    .o_last      (o_last),
    .o_status    (o_status)
);

@@ dv/cursor_line_edit_buffer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_core_tb
// Self-checking bench for the keystroke line editor. A queue of keystroke
// words feeds a clocked driver. A clocked monitor keeps its own copy of the
// line, cursor and length, predicts the result words of each taken keystroke
// and checks every result word against the oldest prediction. Both channels
// stall in random bursts.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_core_tb
    import cleb_pkg::*;
();

    localparam int DEPTH       = LINE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 30;
    localparam int QUIET_WORDS = 30;

    localparam logic [7:0] CH_0 = "0";
    localparam logic [7:0] CH_9 = "9";
    localparam logic [7:0] CH_A = "A";
    localparam logic [7:0] CH_Z = "Z";
    localparam logic [7:0] CH_a = "a";
    localparam logic [7:0] CH_z = "z";

    typedef struct packed {
        logic       op;
        logic [7:0] key;
        logic       drain;   // marker: hold off until every result is back
        logic       quiet;   // no idling once this word goes out
    } t_key_word;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] status;
    } t_line_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_op        = OP_KEY;
    logic [7:0] i_key       = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic       o_last;
    logic [1:0] o_status;

    t_key_word    keystrokes_to_send[$];
    t_line_result expected_results[$];

    // shadow of the editor state
    logic [7:0] line_mem[DEPTH];
    int         line_len  = 0;
    int         cursor    = 0;

    int  errors       = 0;
    int  words_taken  = 0;
    int  results_seen = 0;
    int  n_flushed    = 0;
    int  n_empty      = 0;
    int  n_invalid    = 0;
    int  n_dropped    = 0;
    int  longest_line = 0;
    int  cycles       = 0;

    int   send_gap    = 0;
    int   out_gap     = 0;
    logic draining    = 1'b0;
    logic calm        = 1'b0;
    logic idle_on     = 1'b0;
    logic [5:0] idle_phase = '0;

    cursor_line_edit_buffer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic is_letter(input logic [7:0] k);
        return (k >= CH_A && k <= CH_Z) || (k >= CH_a && k <= CH_z);
    endfunction

    function automatic logic is_text_key(input logic [7:0] k);
        return (k >= CH_0 && k <= CH_9) || is_letter(k);
    endfunction

    task automatic push_result(input logic [7:0] ch, input logic last,
                               input logic [1:0] status);
        t_line_result r;
        r.ch     = ch;
        r.last   = last;
        r.status = status;
        expected_results.push_back(r);
    endtask

    // apply one taken keystroke word to the shadow line, queue its results
    task automatic edit_line(input logic op, input logic [7:0] key);
        int i;
        if (op == OP_FINISH) begin
            if (line_len == 0) begin
                push_result(8'h00, 1'b1, ST_EMPTY);
                n_empty++;
            end else begin
                for (i = 0; i < line_len; i++)
                    push_result(line_mem[i], i == line_len - 1, ST_CHAR);
                if (line_len > longest_line)
                    longest_line = line_len;
                n_flushed++;
                line_len = 0;
                cursor   = 0;
            end
        end else if (is_text_key(key)) begin
            if (line_len >= DEPTH) begin
                push_result(key, 1'b1, ST_FULL);
                n_dropped++;
            end else begin
                for (i = line_len; i > cursor; i--)
                    line_mem[i] = line_mem[i - 1];
                line_mem[cursor] = key;
                line_len++;
                cursor++;
            end
        end else begin
            case (key)
                KEY_LEFT: begin
                    if (cursor > 0)
                        cursor--;
                end
                KEY_RIGHT: begin
                    if (cursor < line_len)
                        cursor++;
                end
                KEY_PLUS: begin
                    // case flip of a letter; digits stay
                    if (cursor > 0 && is_letter(line_mem[cursor - 1]))
                        line_mem[cursor - 1] = line_mem[cursor - 1] ^ 8'h20;
                end
                KEY_MINUS: begin
                    if (cursor > 0) begin
                        for (i = cursor; i < line_len; i++)
                            line_mem[i - 1] = line_mem[i];
                        line_len--;
                        cursor--;
                    end
                end
                default: begin
                    push_result(key, 1'b1, ST_INVALID);
                    n_invalid++;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string field, input int exp_val,
                                   input int got_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, field, exp_val, got_val);
        errors++;
    endtask

    // stimulus helpers
    task automatic queue_word(input logic op, input logic [7:0] key);
        t_key_word w;
        w.op    = op;
        w.key   = key;
        w.drain = 1'b0;
        w.quiet = 1'b0;
        keystrokes_to_send.push_back(w);
    endtask

    task automatic queue_drain();
        t_key_word w;
        w       = '0;
        w.drain = 1'b1;
        keystrokes_to_send.push_back(w);
    endtask

    function automatic logic [7:0] pick_text_key();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return CH_0 + 8'(r);
        else if (r < 36)
            return CH_A + 8'(r - 10);
        else
            return CH_a + 8'(r - 36);
    endfunction

    function automatic logic [7:0] pick_edit_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return pick_text_key();
        else if (r < 60)
            return KEY_LEFT;
        else if (r < 70)
            return KEY_RIGHT;
        else if (r < 80)
            return KEY_PLUS;
        else if (r < 90)
            return KEY_MINUS;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // input driver: one word in flight, random gaps after taken words
    always @(posedge i_clk) begin
        t_key_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (draining) begin
                i_in_valid <= 1'b0;
                if (expected_results.size() == 0)
                    draining = 1'b0;
            end else if (keystrokes_to_send.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (keystrokes_to_send[0].drain) begin
                w = keystrokes_to_send.pop_front();
                draining = 1'b1;
                i_in_valid <= 1'b0;
            end else begin
                w = keystrokes_to_send.pop_front();
                i_in_valid <= 1'b1;
                i_op       <= w.op;
                i_key      <= w.key;
                calm       <= w.quiet;
                if (idle_on && !w.quiet && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 14);
            end
        end
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || calm || !idle_on) begin
            i_out_ready <= 1'b1;
        end else if (out_gap != 0) begin
            out_gap = out_gap - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(1, 14) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // idling switches on and off in stretches
    always @(posedge i_clk) begin
        idle_phase <= idle_phase + 6'd1;
        if (idle_phase == '0)
            idle_on <= ($urandom_range(0, 2) != 0);
    end

    // monitor: check result words, then predict from the taken keystroke
    always @(posedge i_clk) begin
        t_line_result e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0h/%0b/%0d",
                             $time, o_char_out, o_last, o_status);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_char_out !== e.ch)
                        report_mismatch("char_out", e.ch, o_char_out);
                    if (o_last !== e.last)
                        report_mismatch("last", e.last, o_last);
                    if (o_status !== e.status)
                        report_mismatch("status", e.status, o_status);
                end
            end
            if (i_in_valid && o_in_ready) begin
                words_taken++;
                edit_line(i_op, i_key);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("cursor_line_edit_buffer_core verification failed");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        int i;
        logic full_done;
        full_done = 1'b0;

        // directed: empty-line cases, invalid keys, field extremes, edits
        queue_word(OP_FINISH, 8'hFF);      // empty line, key ignored
        queue_word(OP_KEY, KEY_LEFT);      // cursor already at start
        queue_word(OP_KEY, KEY_PLUS);      // nothing before cursor
        queue_word(OP_KEY, KEY_MINUS);
        queue_word(OP_KEY, KEY_RIGHT);     // cursor already at end
        queue_word(OP_KEY, 8'h00);
        queue_word(OP_KEY, 8'hFF);
        queue_word(OP_KEY, 8'h80);
        queue_word(OP_KEY, 8'h2F);         // just below the digits
        queue_word(OP_KEY, 8'h7B);         // just above lowercase
        queue_word(OP_KEY, CH_0);
        queue_word(OP_KEY, CH_9);
        queue_word(OP_KEY, CH_A);
        queue_word(OP_KEY, CH_Z);
        queue_word(OP_KEY, CH_a);
        queue_word(OP_KEY, CH_z);
        queue_word(OP_KEY, KEY_PLUS);      // lower to upper
        queue_word(OP_KEY, KEY_LEFT);
        queue_word(OP_KEY, KEY_LEFT);
        queue_word(OP_KEY, KEY_LEFT);
        queue_word(OP_KEY, KEY_LEFT);
        queue_word(OP_KEY, KEY_PLUS);      // digit before cursor, unchanged
        queue_word(OP_KEY, KEY_MINUS);     // delete mid-line
        queue_word(OP_KEY, KEY_RIGHT);
        queue_word(OP_FINISH, 8'h00);
        queue_drain();

        // random: mostly edited lines closed by a finish, some noise,
        // one line filled past its depth
        n = 25;
        while (n < 260) begin
            if (!full_done && n >= 90) begin
                full_done = 1'b1;
                for (i = 0; i < DEPTH + 2; i++) begin
                    queue_word(OP_KEY, pick_text_key());
                    n++;
                    if ($urandom_range(0, 9) == 0) begin
                        queue_word(OP_KEY, $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT);
                        n++;
                    end
                end
                queue_word(OP_KEY, KEY_PLUS);
                queue_word(OP_KEY, KEY_MINUS);
                queue_word(OP_KEY, pick_text_key());
                queue_word(OP_KEY, pick_text_key());   // full again
                queue_word(OP_FINISH, 8'($urandom_range(0, 255)));
                queue_drain();
                n += 5;
            end else if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                n += k;
            end else begin
                k = $urandom_range(1, 20);
                for (i = 0; i < k; i++)
                    queue_word(OP_KEY, pick_edit_key());
                queue_word(OP_FINISH, 8'($urandom_range(0, 255)));
                n += k + 1;
            end
        end
        for (i = keystrokes_to_send.size() - QUIET_WORDS; i < keystrokes_to_send.size(); i++)
            keystrokes_to_send[i].quiet = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (keystrokes_to_send.size() != 0 || i_in_valid || draining ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d result words never arrived",
                     $time, expected_results.size());
            errors++;
        end

        $display("Covered %0d keystroke words and %0d result words: %0d lines flushed",
                 words_taken, results_seen, n_flushed);
        $display("(longest %0d chars), %0d empty finishes, %0d invalid keys, %0d dropped inserts",
                 longest_line, n_empty, n_invalid, n_dropped);
        if (errors == 0) begin
            $display("cursor_line_edit_buffer_core verification clean");
        end else begin
            $display("cursor_line_edit_buffer_core verification failed");
        end
        $finish;
    end

endmodule
